FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define IHP_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define IHP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ihp_pkg.sv
// ---------------------------------------------------------------------------
// ihp_pkg
// Types, widths and codes of the indexed max-heap with paired-user keys.
// ---------------------------------------------------------------------------
package ihp_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int USER_W     = 4;
	localparam int PRI_W      = 32;
	localparam int IDX_W      = 8;
	localparam int CNT_W      = 9;
	localparam int KEY_W      = 2 * USER_W;

	// One heap slot.
	typedef struct packed {
		logic [USER_W-1:0]       ua;
		logic [USER_W-1:0]       ub;
		logic signed [PRI_W-1:0] pr;
	} entry_t;

	// One write or clear of the position table.
	typedef struct packed {
		logic             en;
		logic             set;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] slot;
	} pos_wr_t;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_EXTRACT = 2'd1,
		KIND_CHANGE  = 2'd2,
		KIND_REMOVE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FULL    = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_BAD_POS = 3'd4
	} status_t;

	// Slot index of the parent.
	function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] d;
		d = i - IDX_W'(1);
		return d >> 1;
	endfunction

endpackage

FILE: sv/ihp_ram.sv
// ---------------------------------------------------------------------------
// ihp_ram
// Simple dual-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module ihp_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/ihp_pos_table.sv
// ---------------------------------------------------------------------------
// ihp_pos_table
// Key to heap slot table: slot memory plus one valid flop per key.
// ---------------------------------------------------------------------------
module ihp_pos_table import ihp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  pos_wr_t          wr,
	input  logic             rd_en,
	input  logic [KEY_W-1:0] rd_key,
	output logic [IDX_W-1:0] rd_slot,
	output logic             rd_valid
);

	localparam int KEY_COUNT = 1 << KEY_W;

	logic [IDX_W-1:0] slot_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] valid_q;

	// Valid bits are cleared by reset, so every key starts absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.key] <= wr.set;
		end
	end

	// Slot memory and registered lookup.
	always_ff @(posedge clk) begin
		if (wr.en && wr.set) begin
			slot_mem[wr.key] <= wr.slot;
		end
		if (rd_en) begin
			rd_slot  <= slot_mem[rd_key];
			rd_valid <= valid_q[rd_key];
		end
	end

endmodule

FILE: sv/indexed_max_heap_pair_keys_top.sv
// ---------------------------------------------------------------------------
// indexed_max_heap_pair_keys_top
// Indexed binary max-heap with a sequencer over the heap RAM and key table.
// ---------------------------------------------------------------------------
// A failed transaction goes straight to the result, and a change of an absent
// key first looks up the key table; otherwise the time grows with each heap
// level walked, most for a remove of the deepest slot of a full heap.
// Throughput: one transaction at a time; busy falls in the cycle of the strobe.
// Reset: entry count zero and all keys absent at once; heap slots are written
// before they are read. The result is shown for one cycle and cannot be stalled.
module indexed_max_heap_pair_keys_top import ihp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic [USER_W-1:0]       user_a,
	input  logic [USER_W-1:0]       user_b,
	input  logic signed [PRI_W-1:0] priority_req,
	input  logic [IDX_W-1:0]        position,
	input  logic                    mirror,
	output logic                    done,
	output logic [2:0]              status,
	output logic [USER_W-1:0]       out_user_a,
	output logic [USER_W-1:0]       out_user_b,
	output logic signed [PRI_W-1:0] out_priority,
	output logic                    top_valid,
	output logic [USER_W-1:0]       top_user_a,
	output logic [USER_W-1:0]       top_user_b,
	output logic signed [PRI_W-1:0] top_priority,
	output logic [CNT_W-1:0]        entry_total
);
`include "assert_macros.svh"

	typedef enum logic [4:0] {
		S_IDLE, S_SW_A, S_SW_AR, S_SW_B, S_SW_BR,
		S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_L, S_DN_R,
		S_EXT_RD, S_EXT_GET, S_EXT_FR, S_EXT_NEXT, S_EXT_LAST,
		S_CHG_LK, S_CHG_RD, S_RM_LD, S_RM_RD, S_RM_SW,
		S_FIN, S_OUT
	} state_t;

	state_t           state_q, ret_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] i_q, sa_q, sb_q;
	entry_t           cur_q, na_q, nb_q, left_q, got_q;
	logic             one_q, mir_q;
	logic signed [PRI_W-1:0] pr_q;
	status_t          status_q;
	logic             done_q;
	entry_t           top_q;
	logic             top_valid_q;

	// Heap RAM ports.
	logic             h_we, h_re;
	logic [IDX_W-1:0] h_waddr, h_raddr;
	entry_t           h_wdata, h_rdata;

	// Position table ports.
	pos_wr_t          p_wr;
	logic             p_re;
	logic [IDX_W-1:0] p_slot;
	logic             p_valid;

	ihp_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	ihp_pos_table u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (p_wr),
		.rd_en    (p_re),
		.rd_key   ({user_a, user_b}),
		.rd_slot  (p_slot),
		.rd_valid (p_valid)
	);

	// Child indexes, one bit wider so that they compare against the count.
	logic [CNT_W:0]   left_idx, right_idx;
	logic             left_ok, right_ok;
	assign left_idx  = {1'b0, i_q, 1'b1};
	assign right_idx = {1'b0, i_q, 1'b0} + (CNT_W+1)'(2);
	assign left_ok   = left_idx < {1'b0, cnt_q};
	assign right_ok  = right_idx < {1'b0, cnt_q};

	// Sift-down choice among current entry, left child and optional right child.
	entry_t           dn_lval, dn_best;
	logic             dn_has_r, dn_move;
	logic [IDX_W-1:0] dn_m;
	always_comb begin
		dn_lval  = (state_q == S_DN_L) ? h_rdata : left_q;
		dn_has_r = (state_q == S_DN_R);
		dn_best  = cur_q;
		dn_m     = i_q;
		dn_move  = 1'b0;
		if ($signed(dn_lval.pr) > $signed(cur_q.pr)) begin
			dn_best = dn_lval;
			dn_m    = left_idx[IDX_W-1:0];
			dn_move = 1'b1;
		end
		if (dn_has_r && ($signed(h_rdata.pr) > $signed(dn_best.pr))) begin
			dn_best = h_rdata;
			dn_m    = right_idx[IDX_W-1:0];
			dn_move = 1'b1;
		end
	end

	// Memory access decode for the current step.
	always_comb begin
		h_we    = 1'b0;
		h_waddr = sa_q;
		h_wdata = na_q;
		h_re    = 1'b0;
		h_raddr = '0;
		p_wr    = '0;
		p_re    = 1'b0;
		case (state_q)
			S_IDLE: begin
				p_re    = start && (kind == KIND_CHANGE);
				h_re    = start && (kind == KIND_REMOVE) && ({1'b0, position} < cnt_q);
				h_raddr = position;
			end
			S_SW_A: begin
				h_we = 1'b1;
				p_wr = '{en: 1'b1, set: 1'b1, key: {na_q.ua, na_q.ub}, slot: sa_q};
			end
			S_SW_AR: begin
				p_wr = '{en: 1'b1, set: 1'b1, key: {na_q.ub, na_q.ua}, slot: sa_q};
			end
			S_SW_B: begin
				h_we    = 1'b1;
				h_waddr = sb_q;
				h_wdata = nb_q;
				p_wr    = '{en: 1'b1, set: 1'b1, key: {nb_q.ua, nb_q.ub}, slot: sb_q};
			end
			S_SW_BR: begin
				p_wr = '{en: 1'b1, set: 1'b1, key: {nb_q.ub, nb_q.ua}, slot: sb_q};
			end
			S_UP_RD, S_RM_RD: begin
				h_re    = (i_q != '0);
				h_raddr = parent_of(i_q);
			end
			S_DN_RD: begin
				h_re    = left_ok;
				h_raddr = left_idx[IDX_W-1:0];
			end
			S_DN_L: begin
				h_re    = right_ok;
				h_raddr = right_idx[IDX_W-1:0];
			end
			S_EXT_RD: begin
				h_re    = 1'b1;
				h_raddr = '0;
			end
			S_FIN: begin
				h_re    = (cnt_q != '0);
				h_raddr = '0;
			end
			S_EXT_GET: begin
				p_wr = '{en: 1'b1, set: 1'b0, key: {h_rdata.ua, h_rdata.ub}, slot: '0};
			end
			S_EXT_FR: begin
				p_wr = '{en: 1'b1, set: 1'b0, key: {got_q.ub, got_q.ua}, slot: '0};
			end
			S_EXT_NEXT: begin
				h_re    = (cnt_q != '0);
				h_raddr = cnt_q[IDX_W-1:0];
			end
			S_CHG_LK: begin
				h_re    = p_valid && ({1'b0, p_slot} < cnt_q);
				h_raddr = p_slot;
			end
			S_CHG_RD: begin
				h_we    = 1'b1;
				h_waddr = i_q;
				h_wdata = '{ua: h_rdata.ua, ub: h_rdata.ub, pr: pr_q};
			end
			default: begin
			end
		endcase
	end

	// Sequencer: state, working registers and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			one_q    <= 1'b0;
			mir_q    <= 1'b0;
			status_q <= ST_OK;
			i_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mir_q    <= mirror;
						pr_q     <= priority_req;
						status_q <= ST_OK;
						got_q    <= '0;
						case (kind_t'(kind))
							KIND_INSERT: begin
								if (cnt_q >= CNT_W'(HEAP_DEPTH)) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									cur_q   <= '{ua: user_a, ub: user_b, pr: priority_req};
									na_q    <= '{ua: user_a, ub: user_b, pr: priority_req};
									sa_q    <= cnt_q[IDX_W-1:0];
									i_q     <= cnt_q[IDX_W-1:0];
									cnt_q   <= cnt_q + CNT_W'(1);
									one_q   <= 1'b1;
									ret_q   <= S_UP_RD;
									state_q <= S_SW_A;
								end
							end
							KIND_EXTRACT: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_EXT_RD;
								end
							end
							KIND_CHANGE: begin
								state_q <= S_CHG_LK;
							end
							default: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else if ({1'b0, position} >= cnt_q) begin
									status_q <= ST_BAD_POS;
									state_q  <= S_FIN;
								end else begin
									i_q     <= position;
									state_q <= S_RM_LD;
								end
							end
						endcase
					end
				end
				// Swap write sequence: slot A then slot B (slot A alone when one_q is set), each with its key notes.
				S_SW_A: begin
					state_q <= mir_q ? S_SW_AR : (one_q ? ret_q : S_SW_B);
				end
				S_SW_AR: begin
					state_q <= one_q ? ret_q : S_SW_B;
				end
				S_SW_B: begin
					state_q <= mir_q ? S_SW_BR : ret_q;
				end
				S_SW_BR: begin
					state_q <= ret_q;
				end
				// Sift up: climb while the parent is strictly smaller.
				S_UP_RD: begin
					state_q <= (i_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if ($signed(h_rdata.pr) < $signed(cur_q.pr)) begin
						sa_q    <= parent_of(i_q);
						na_q    <= cur_q;
						sb_q    <= i_q;
						nb_q    <= h_rdata;
						i_q     <= parent_of(i_q);
						one_q   <= 1'b0;
						ret_q   <= S_UP_RD;
						state_q <= S_SW_A;
					end else begin
						state_q <= S_FIN;
					end
				end
				// Sift down: left child wins ties.
				S_DN_RD: begin
					state_q <= left_ok ? S_DN_L : S_FIN;
				end
				S_DN_L, S_DN_R: begin
					if (state_q == S_DN_L && right_ok) begin
						left_q  <= h_rdata;
						state_q <= S_DN_R;
					end else if (dn_move) begin
						sa_q    <= i_q;
						na_q    <= dn_best;
						sb_q    <= dn_m;
						nb_q    <= cur_q;
						i_q     <= dn_m;
						one_q   <= 1'b0;
						ret_q   <= S_DN_RD;
						state_q <= S_SW_A;
					end else begin
						state_q <= S_FIN;
					end
				end
				// Extract the root and move the last entry into its place.
				S_EXT_RD: begin
					state_q <= S_EXT_GET;
				end
				S_EXT_GET: begin
					got_q   <= h_rdata;
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= mir_q ? S_EXT_FR : S_EXT_NEXT;
				end
				S_EXT_FR: begin
					state_q <= S_EXT_NEXT;
				end
				S_EXT_NEXT: begin
					state_q <= (cnt_q != '0) ? S_EXT_LAST : S_FIN;
				end
				S_EXT_LAST: begin
					cur_q   <= h_rdata;
					na_q    <= h_rdata;
					sa_q    <= '0;
					i_q     <= '0;
					one_q   <= 1'b1;
					ret_q   <= S_DN_RD;
					state_q <= S_SW_A;
				end
				// Change priority of a keyed entry.
				S_CHG_LK: begin
					if (!p_valid || ({1'b0, p_slot} >= cnt_q)) begin
						status_q <= ST_ABSENT;
						state_q  <= S_FIN;
					end else begin
						i_q     <= p_slot;
						state_q <= S_CHG_RD;
					end
				end
				S_CHG_RD: begin
					cur_q   <= '{ua: h_rdata.ua, ub: h_rdata.ub, pr: pr_q};
					state_q <= ($signed(pr_q) > $signed(h_rdata.pr)) ? S_UP_RD : S_DN_RD;
				end
				// Remove: carry the entry up to the root, then extract it.
				S_RM_LD: begin
					cur_q   <= h_rdata;
					state_q <= S_RM_RD;
				end
				S_RM_RD: begin
					state_q <= (i_q == '0) ? S_EXT_RD : S_RM_SW;
				end
				S_RM_SW: begin
					sa_q    <= i_q;
					na_q    <= h_rdata;
					sb_q    <= parent_of(i_q);
					nb_q    <= cur_q;
					i_q     <= parent_of(i_q);
					one_q   <= 1'b0;
					ret_q   <= S_RM_RD;
					state_q <= S_SW_A;
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					top_valid_q <= (cnt_q != '0);
					top_q       <= (cnt_q != '0) ? h_rdata : '0;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output ports.
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_user_a   = got_q.ua;
	assign out_user_b   = got_q.ub;
	assign out_priority = got_q.pr;
	assign top_valid    = top_valid_q;
	assign top_user_a   = top_q.ua;
	assign top_user_b   = top_q.ub;
	assign top_priority = top_q.pr;
	assign entry_total  = cnt_q;

	// Checks on the sequencer.
	`IHP_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(HEAP_DEPTH), "entry count above depth")
	`IHP_ASSERT_IMPLY(a_done_idle, done, !busy, "result strobe while busy")
	`IHP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not start")
	`IHP_ASSERT_IMPLY(a_top_valid, done, top_valid == (entry_total != '0), "top valid mismatch")

endmodule

FILE: tb/sv/indexed_max_heap_pair_keys_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_max_heap_pair_keys_top_tb
// Self-checking bench for the indexed max-heap with paired-user keys. A
// behavioral heap with its own key table predicts every result. Directed
// corner cases come first, then random traffic that fills and drains the heap.
// ---------------------------------------------------------------------------
module indexed_max_heap_pair_keys_top_tb;
	import ihp_pkg::*;

	localparam int CYCLE_LIMIT = 900000;

	// One request as presented to the block.
	typedef struct packed {
		kind_t                   kind;
		logic [USER_W-1:0]       ua;
		logic [USER_W-1:0]       ub;
		logic signed [PRI_W-1:0] pr;
		logic [IDX_W-1:0]        pos;
		logic                    mir;
	} request_t;

	// One result as seen at the strobe.
	typedef struct packed {
		status_t                 st;
		logic [USER_W-1:0]       oa;
		logic [USER_W-1:0]       ob;
		logic signed [PRI_W-1:0] opr;
		logic                    tv;
		logic [USER_W-1:0]       ta;
		logic [USER_W-1:0]       tb;
		logic signed [PRI_W-1:0] tpr;
		logic [CNT_W-1:0]        cnt;
	} outcome_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              kind;
	logic [USER_W-1:0]       user_a;
	logic [USER_W-1:0]       user_b;
	logic signed [PRI_W-1:0] priority_req;
	logic [IDX_W-1:0]        position;
	logic                    mirror;
	logic                    done;
	logic [2:0]              status;
	logic [USER_W-1:0]       out_user_a;
	logic [USER_W-1:0]       out_user_b;
	logic signed [PRI_W-1:0] out_priority;
	logic                    top_valid;
	logic [USER_W-1:0]       top_user_a;
	logic [USER_W-1:0]       top_user_b;
	logic signed [PRI_W-1:0] top_priority;
	logic [CNT_W-1:0]        entry_total;

	indexed_max_heap_pair_keys_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .user_a(user_a), .user_b(user_b),
		.priority_req(priority_req), .position(position), .mirror(mirror),
		.done(done), .status(status), .out_user_a(out_user_a),
		.out_user_b(out_user_b), .out_priority(out_priority),
		.top_valid(top_valid), .top_user_a(top_user_a),
		.top_user_b(top_user_b), .top_priority(top_priority),
		.entry_total(entry_total)
	);

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	int       idle_pct;
	int       error_count = 0;
	int       cycle_count = 0;

	// Behavioral heap and key table.
	entry_t         heap_mem[HEAP_DEPTH];
	logic [IDX_W:0] key_slot[256] = '{default: '0};
	bit             key_present[256] = '{default: 1'b0};
	int             heap_count = 0;
	bit             track_mirror = 1'b0;

	// Record slot j under its key, and under the reversed key when tracking.
	function automatic void record_slot(int j);
		int a;
		int b;
		a = heap_mem[j].ua;
		b = heap_mem[j].ub;
		key_slot[a * 16 + b] = (IDX_W+1)'(j);
		key_present[a * 16 + b] = 1;
		if (track_mirror) begin
			key_slot[b * 16 + a] = (IDX_W+1)'(j);
			key_present[b * 16 + a] = 1;
		end
	endfunction

	function automatic void swap_entries(int i, int j);
		entry_t t;
		t = heap_mem[i];
		heap_mem[i] = heap_mem[j];
		heap_mem[j] = t;
		record_slot(i);
		record_slot(j);
	endfunction

	function automatic void bubble_up(int i);
		while (i > 0 && heap_mem[(i - 1) / 2].pr < heap_mem[i].pr) begin
			swap_entries((i - 1) / 2, i);
			i = (i - 1) / 2;
		end
	endfunction

	// Left child wins ties because the right one must be strictly greater.
	function automatic void bubble_down(int i);
		int m;
		int l;
		int r;
		forever begin
			m = i;
			l = 2 * i + 1;
			r = 2 * i + 2;
			if (l < heap_count && heap_mem[l].pr > heap_mem[m].pr) m = l;
			if (r < heap_count && heap_mem[r].pr > heap_mem[m].pr) m = r;
			if (m == i) return;
			swap_entries(i, m);
			i = m;
		end
	endfunction

	function automatic entry_t pop_root();
		entry_t t;
		t = heap_mem[0];
		heap_count--;
		key_present[t.ua * 16 + t.ub] = 0;
		if (track_mirror) key_present[t.ub * 16 + t.ua] = 0;
		if (heap_count > 0) begin
			heap_mem[0] = heap_mem[heap_count];
			record_slot(0);
			bubble_down(0);
		end
		return t;
	endfunction

	// Apply one request to the heap and return the outcome it yields.
	function automatic outcome_t apply_request(request_t q);
		outcome_t o;
		entry_t   got;
		int       k;
		int       i;
		logic signed [PRI_W-1:0] old;
		o = '0;
		got = '0;
		o.st = ST_OK;
		track_mirror = q.mir;
		case (q.kind)
			KIND_INSERT: begin
				if (heap_count >= HEAP_DEPTH) o.st = ST_FULL;
				else begin
					heap_mem[heap_count] = '{ua: q.ua, ub: q.ub, pr: q.pr};
					heap_count++;
					record_slot(heap_count - 1);
					bubble_up(heap_count - 1);
				end
			end
			KIND_EXTRACT: begin
				if (heap_count == 0) o.st = ST_EMPTY;
				else got = pop_root();
			end
			KIND_CHANGE: begin
				k = q.ua * 16 + q.ub;
				i = key_slot[k];
				if (!key_present[k] || i >= heap_count) o.st = ST_ABSENT;
				else begin
					old = heap_mem[i].pr;
					heap_mem[i].pr = q.pr;
					if (q.pr > old) bubble_up(i);
					else bubble_down(i);
				end
			end
			default: begin
				if (heap_count == 0) o.st = ST_EMPTY;
				else if (q.pos >= heap_count) o.st = ST_BAD_POS;
				else begin
					i = q.pos;
					while (i > 0) begin
						swap_entries(i, (i - 1) / 2);
						i = (i - 1) / 2;
					end
					got = pop_root();
				end
			end
		endcase
		o.oa = got.ua;
		o.ob = got.ub;
		o.opr = got.pr;
		if (heap_count > 0) begin
			o.tv = 1'b1;
			o.ta = heap_mem[0].ua;
			o.tb = heap_mem[0].ub;
			o.tpr = heap_mem[0].pr;
		end
		o.cnt = CNT_W'(heap_count);
		return o;
	endfunction

	function automatic logic signed [PRI_W-1:0] rand_priority();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed(32'($urandom_range(0, 7)) << 16);
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic request_t make_request(kind_t k, int ua, int ub,
		logic signed [PRI_W-1:0] pr, int pos, bit mir);
		request_t q;
		q.kind = k;
		q.ua = USER_W'(ua);
		q.ub = USER_W'(ub);
		q.pr = pr;
		q.pos = IDX_W'(pos);
		q.mir = mir;
		return q;
	endfunction

	// Append a request to the tail of the pending queue.
	function automatic void queue_request(request_t q);
		pending_requests.insert(pending_requests.size(), q);
	endfunction

	// Random request; fill_bias sets the share of inserts in percent.
	function automatic request_t rand_request(int fill_bias);
		int     r;
		kind_t  k;
		r = $urandom_range(0, 99);
		if (r < fill_bias) k = KIND_INSERT;
		else begin
			case ($urandom_range(0, 2))
				0: k = KIND_EXTRACT;
				1: k = KIND_CHANGE;
				default: k = KIND_REMOVE;
			endcase
		end
		return make_request(k, $urandom_range(0, 15), $urandom_range(0, 15),
			rand_priority(), $urandom_range(0, 255), $urandom_range(0, 1));
	endfunction

	// Free-running clock.
	always #4 clk = ~clk;

	// Driver: present the next request, hold it until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= '0;
			user_a <= '0;
			user_b <= '0;
			priority_req <= '0;
			position <= '0;
			mirror <= 1'b0;
		end else if (!(start && !busy) && start) begin
			// Request still waiting to be taken.
		end else if (pending_requests.size() > 0 &&
			$urandom_range(0, 99) >= idle_pct) begin
			start <= 1'b1;
			kind <= pending_requests[0].kind;
			user_a <= pending_requests[0].ua;
			user_b <= pending_requests[0].ub;
			priority_req <= pending_requests[0].pr;
			position <= pending_requests[0].pos;
			mirror <= pending_requests[0].mir;
			void'(pending_requests.pop_front());
		end else begin
			start <= 1'b0;
		end
	end

	// Predict at acceptance so the order of outcomes follows the transactions.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_outcomes.insert(expected_outcomes.size(),
				apply_request('{kind_t'(kind), user_a, user_b, priority_req,
				position, mirror}));
	end

	// Monitor: compare every strobed result with the oldest prediction.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("result strobe with no transaction outstanding");
				error_count++;
			end else begin
				e = expected_outcomes.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					error_count++;
				end
				if (out_user_a !== e.oa) begin
					$error("out_user_a: expected %0d, got %0d", e.oa, out_user_a);
					error_count++;
				end
				if (out_user_b !== e.ob) begin
					$error("out_user_b: expected %0d, got %0d", e.ob, out_user_b);
					error_count++;
				end
				if (out_priority !== e.opr) begin
					$error("out_priority: expected %0d, got %0d", e.opr, out_priority);
					error_count++;
				end
				if (top_valid !== e.tv) begin
					$error("top_valid: expected %0d, got %0d", e.tv, top_valid);
					error_count++;
				end
				if (top_user_a !== e.ta) begin
					$error("top_user_a: expected %0d, got %0d", e.ta, top_user_a);
					error_count++;
				end
				if (top_user_b !== e.tb) begin
					$error("top_user_b: expected %0d, got %0d", e.tb, top_user_b);
					error_count++;
				end
				if (top_priority !== e.tpr) begin
					$error("top_priority: expected %0d, got %0d", e.tpr, top_priority);
					error_count++;
				end
				if (entry_total !== e.cnt) begin
					$error("entry_total: expected %0d, got %0d", e.cnt, entry_total);
					error_count++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** indexed_max_heap_pair_keys_top: FAILED **");
			$finish;
		end
	end

	// Stimulus: directed corners, then phased random traffic.
	initial begin
		int phase;
		int n;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty heap: extract, remove and change all fail.
		queue_request(make_request(KIND_EXTRACT, 0, 0, 0, 0, 0));
		queue_request(make_request(KIND_REMOVE, 15, 15, 0, 255, 1));
		queue_request(make_request(KIND_CHANGE, 3, 4, 5, 0, 0));
		// Extreme priorities, a duplicate key, and a mirrored key.
		queue_request(make_request(KIND_INSERT, 0, 0, 32'sh8000_0000, 0, 0));
		queue_request(make_request(KIND_INSERT, 15, 15, 32'sh7FFF_FFFF, 255, 1));
		queue_request(make_request(KIND_INSERT, 3, 9, 32'sh0001_0000, 0, 1));
		queue_request(make_request(KIND_INSERT, 3, 9, 32'sh0001_0000, 0, 0));
		queue_request(make_request(KIND_INSERT, 5, 6, 32'sh0001_0000, 0, 0));
		// Change via the mirrored key, up, then down, then equal, then an absent key.
		queue_request(make_request(KIND_CHANGE, 9, 3, 32'sh7FFF_FFFF, 0, 0));
		queue_request(make_request(KIND_CHANGE, 5, 6, 32'sh8000_0000, 0, 1));
		queue_request(make_request(KIND_CHANGE, 5, 6, 32'sh8000_0000, 0, 0));
		queue_request(make_request(KIND_CHANGE, 7, 7, 0, 0, 0));
		// Remove at a bad slot, at a leaf, at the root; then extract.
		queue_request(make_request(KIND_REMOVE, 0, 0, 0, 200, 0));
		queue_request(make_request(KIND_REMOVE, 0, 0, 0, 4, 1));
		queue_request(make_request(KIND_REMOVE, 0, 0, 0, 0, 0));
		queue_request(make_request(KIND_EXTRACT, 0, 0, 0, 0, 1));
		queue_request(make_request(KIND_EXTRACT, 0, 0, 0, 0, 0));
		queue_request(make_request(KIND_EXTRACT, 0, 0, 0, 0, 0));
		wait (pending_requests.size() == 0 && expected_outcomes.size() == 0);

		// Fill to capacity and overflow twice.
		for (int k = 0; k < HEAP_DEPTH + 2; k++)
			queue_request(make_request(KIND_INSERT, $urandom_range(0, 15),
				$urandom_range(0, 15), rand_priority(), 0, $urandom_range(0, 1)));
		for (int k = 0; k < 40; k++)
			queue_request(rand_request(10));
		wait (pending_requests.size() == 0 && expected_outcomes.size() == 0);

		// Random phases with differing sender idling and mix.
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 58 : (phase == 2) ? 28 : 0;
			for (n = 0; n < 400; n++)
				queue_request(rand_request(phase == 3 ? 35 : 55));
			wait (pending_requests.size() == 0 && expected_outcomes.size() == 0);
		end

		repeat (40) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("** indexed_max_heap_pair_keys_top: PASSED **");
		else
			$display("** indexed_max_heap_pair_keys_top: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/ihp_pkg.sv
sv/ihp_ram.sv
sv/ihp_pos_table.sv
sv/indexed_max_heap_pair_keys_top.sv
tb/sv/indexed_max_heap_pair_keys_top_tb.sv
